@@ design/adcfr_pkg.sv @@
`timescale 1ns / 1ps
package adcfr_pkg;

   localparam int QUEUE_DEPTH    = 15;
   localparam int CONVERTER_REGS = 128;

   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CREG_W = $clog2(CONVERTER_REGS);

   localparam logic [9:0] ADDR_CFG    = 10'd0;
   localparam logic [9:0] ADDR_INTSTS = 10'd1;
   localparam logic [9:0] ADDR_INTMSK = 10'd2;
   localparam logic [9:0] ADDR_STATUS = 10'd3;
   localparam logic [9:0] ADDR_CFIFO  = 10'd4;
   localparam logic [9:0] ADDR_DFIFO  = 10'd5;
   localparam logic [9:0] ADDR_CTL    = 10'd6;

   localparam logic [3:0] CMD_NOP   = 4'h0;
   localparam logic [3:0] CMD_READ  = 4'h1;
   localparam logic [3:0] CMD_WRITE = 4'h2;

   localparam logic [31:0] CONFIG_RESET = 32'h0000_1114;
   localparam logic [31:0] INTSTS_RESET = 32'h0000_0200;
   localparam logic [31:0] INTMSK_RESET = 32'hffff_ffff;
   localparam logic [31:0] CTL_RESET    = 32'h0000_0010;

   localparam logic [31:0] INTMSK_WMASK = 32'h0000_03ff;
   localparam logic [31:0] CTL_WMASK    = 32'h00ff_feff;
   localparam logic [31:0] INT_CMD_BIT   = 32'h0000_0200;
   localparam logic [31:0] INT_QUEUE_BIT = 32'h0000_0100;
   localparam logic [31:0] STS_CFIFO_EMPTY = 32'h0000_0400;
   localparam logic [31:0] STS_Q_EMPTY     = 32'h0000_0100;
   localparam logic [31:0] STS_Q_FULL      = 32'h0000_0200;
   localparam int          CTL_RESET_POS   = 4;

   typedef struct packed {
      logic        action;
      logic [9:0]  word_address;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_level;
      logic        access_error;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic        push;
      logic        pop;
      logic        clear;
      logic [15:0] push_data;
   } queue_ctl_type;

   typedef struct packed {
      logic              write_en;
      logic              clear;
      logic [CREG_W-1:0] addr;
      logic [15:0]       data;
   } conv_ctl_type;

endpackage

@@ design/adcfr_conv_ram.sv @@
`timescale 1ns / 1ps
module adcfr_conv_ram (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [adcfr_pkg::CREG_W-1:0] rd_addr,
   input  adcfr_pkg::conv_ctl_type      conv_ctl,
   output logic [15:0]                  rd_data
);
   import adcfr_pkg::*;

   logic [15:0]               mem_ff [CONVERTER_REGS];
   logic [CONVERTER_REGS-1:0] valid_ff;
   logic [CONVERTER_REGS-1:0] valid_in;
   logic [15:0]               rd_raw_ff;
   logic                      rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (conv_ctl.clear) begin
         valid_in = '0;
      end else if (conv_ctl.write_en) begin
         valid_in[conv_ctl.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (conv_ctl.write_en) begin
         mem_ff[conv_ctl.addr] <= conv_ctl.data;
      end
      if (rd_en) begin
         rd_raw_ff   <= mem_ff[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : 16'h0000;

endmodule

@@ design/adcfr_queue.sv @@
`timescale 1ns / 1ps
module adcfr_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  adcfr_pkg::queue_ctl_type     queue_ctl,
   output logic [15:0]                  head_data,
   output logic [adcfr_pkg::QCNT_W-1:0] count
);
   import adcfr_pkg::*;

   logic [15:0]       mem_ff [QUEUE_DEPTH];
   logic [15:0]       head_raw_ff;
   logic [QPTR_W-1:0] head_ff;
   logic [QPTR_W-1:0] head_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic [QCNT_W:0]   tail_sum;
   logic [QCNT_W:0]   tail_wrap;
   logic [QPTR_W-1:0] tail;
   logic              full;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign tail_sum  = (QCNT_W + 1)'(head_ff) + (QCNT_W + 1)'(count_ff);
   assign tail_wrap = (tail_sum >= (QCNT_W + 1)'(QUEUE_DEPTH))
                      ? tail_sum - (QCNT_W + 1)'(QUEUE_DEPTH) : tail_sum;
   assign tail      = tail_wrap[QPTR_W-1:0];

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      priority if (queue_ctl.clear) begin
         head_in  = '0;
         count_in = '0;
      end else if (queue_ctl.push) begin
         if (!full) begin
            count_in = count_ff + 1'b1;
         end
      end else if (queue_ctl.pop) begin
         count_in = count_ff - 1'b1;
         head_in  = (head_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_ctl.push && !queue_ctl.clear && !full) begin
         mem_ff[tail] <= queue_ctl.push_data;
      end
      if (rd_en) begin
         head_raw_ff <= mem_ff[head_ff];
      end
   end

   assign head_data = head_raw_ff;
   assign count     = count_ff;

endmodule

@@ design/adc_command_fifo_register_block.sv @@
`timescale 1ns / 1ps
// Each accepted beat gives a result strobe. Busy is high for the cycle after
// accept, while the converter register and queue head memory reads complete,
// so the next beat waits. Reset (synchronous, active high) restores the control
// registers to their reset values and clears the latch, queue level and
// converter register valid bits; results cannot be stalled.
module adc_command_fifo_register_block (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  adcfr_pkg::req_type req_payload,
   output logic               rsp_strobe,
   output adcfr_pkg::rsp_type rsp_payload
);
   import adcfr_pkg::*;

   state_type     state_ff;
   state_type     state_in;
   req_type       item_ff;
   logic          accept;

   logic [31:0]   config_ff, config_in;
   logic [31:0]   intsts_ff, intsts_in;
   logic [31:0]   intmsk_ff, intmsk_in;
   logic [31:0]   ctl_ff, ctl_in;
   logic [15:0]   latch_ff, latch_in;
   logic          rsp_strobe_ff;
   rsp_type       rsp_ff, rsp_in;

   queue_ctl_type queue_ctl;
   conv_ctl_type  conv_ctl;
   logic [15:0]   conv_rd_data;
   logic [15:0]   head_data;
   logic [QCNT_W-1:0] q_count;
   logic [QCNT_W-1:0] q_count_pushed;
   logic [3:0]    cmd;

   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy = (state_ff == ST_EXEC);
   end

   adcfr_conv_ram u_conv_ram (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (req_payload.write_data[16 +: CREG_W]),
      .conv_ctl (conv_ctl),
      .rd_data  (conv_rd_data)
   );

   adcfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .queue_ctl (queue_ctl),
      .head_data (head_data),
      .count     (q_count)
   );

   assign cmd            = item_ff.write_data[29:26];
   assign q_count_pushed = (q_count == QCNT_W'(QUEUE_DEPTH)) ? q_count : q_count + 1'b1;

   always_comb begin
      config_in = config_ff;
      intsts_in = intsts_ff;
      intmsk_in = intmsk_ff;
      ctl_in    = ctl_ff;
      latch_in  = latch_ff;
      queue_ctl = '{push: 1'b0, pop: 1'b0, clear: 1'b0, push_data: latch_ff};
      conv_ctl  = '{write_en: 1'b0, clear: 1'b0,
                    addr: item_ff.write_data[16 +: CREG_W],
                    data: item_ff.write_data[15:0]};
      rsp_in    = '0;
      if (state_ff == ST_EXEC) begin
         if (item_ff.action) begin
            unique case (item_ff.word_address)
               ADDR_CFG:    config_in = item_ff.write_data;
               ADDR_INTSTS: intsts_in = intsts_ff & ~item_ff.write_data;
               ADDR_INTMSK: intmsk_in = item_ff.write_data & INTMSK_WMASK;
               ADDR_CFIFO: begin
                  if (cmd == CMD_READ || cmd == CMD_NOP) begin
                     queue_ctl.push = 1'b1;
                     latch_in = (cmd == CMD_READ) ? conv_rd_data : 16'h0000;
                     if (4'(q_count_pushed) > config_ff[19:16]) begin
                        intsts_in = intsts_in | INT_QUEUE_BIT;
                     end
                  end else if (cmd == CMD_WRITE) begin
                     conv_ctl.write_en = 1'b1;
                  end
                  intsts_in = intsts_in | INT_CMD_BIT;
               end
               ADDR_CTL: begin
                  if (item_ff.write_data[CTL_RESET_POS]) begin
                     config_in       = CONFIG_RESET;
                     intsts_in       = INTSTS_RESET;
                     intmsk_in       = INTMSK_RESET;
                     queue_ctl.clear = 1'b1;
                     conv_ctl.clear  = 1'b1;
                  end
                  ctl_in = item_ff.write_data & CTL_WMASK;
               end
               default: rsp_in.access_error = 1'b1;
            endcase
         end else begin
            unique case (item_ff.word_address)
               ADDR_CFG:    rsp_in.read_data = config_ff;
               ADDR_INTSTS: rsp_in.read_data = intsts_ff;
               ADDR_INTMSK: rsp_in.read_data = intmsk_ff;
               ADDR_CTL:    rsp_in.read_data = ctl_ff;
               ADDR_STATUS: begin
                  rsp_in.read_data = STS_CFIFO_EMPTY | (32'(q_count) << 12);
                  if (q_count == '0) begin
                     rsp_in.read_data = rsp_in.read_data | STS_Q_EMPTY;
                  end else if (q_count == QCNT_W'(QUEUE_DEPTH)) begin
                     rsp_in.read_data = rsp_in.read_data | STS_Q_FULL;
                  end
               end
               ADDR_DFIFO: begin
                  if (q_count != '0) begin
                     rsp_in.read_data = 32'(head_data);
                     queue_ctl.pop    = 1'b1;
                  end
               end
               default: rsp_in.access_error = 1'b1;
            endcase
         end
         rsp_in.irq_level = |(intsts_in & ~intmsk_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         config_ff     <= CONFIG_RESET;
         intsts_ff     <= INTSTS_RESET;
         intmsk_ff     <= INTMSK_RESET;
         ctl_ff        <= CTL_RESET;
         latch_ff      <= 16'h0000;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         config_ff     <= config_in;
         intsts_ff     <= intsts_in;
         intmsk_ff     <= intmsk_in;
         ctl_ff        <= ctl_in;
         latch_ff      <= latch_in;
         rsp_strobe_ff <= (state_ff == ST_EXEC);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_payload;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ design/adcfr_checker.sv @@
`timescale 1ns / 1ps
module adcfr_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input adcfr_pkg::rsp_type rsp_payload
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accepted beat");

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held longer than one cycle");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> ##1 rsp_strobe)
      else $error("result beat missing after accept");

   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while busy");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.access_error |-> rsp_payload.read_data == 32'h0)
      else $error("nonzero read data on refused access");

endmodule

bind adc_command_fifo_register_block adcfr_checker u_adcfr_checker (.*);

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
   import adcfr_pkg::*;

   localparam int ITEMS = 1950;

   class adc_reg_scoreboard;
      logic [31:0] cfg_word;
      logic [31:0] int_status;
      logic [31:0] int_mask;
      logic [31:0] ctl_word;
      logic [15:0] conv_regs [CONVERTER_REGS];
      logic [15:0] data_fifo [$];
      logic [15:0] latch_value;
      rsp_type     expected_rsp [$];
      int errors;
      int checked;
      int full_drops;
      int queue_irqs;
      int soft_resets;
      int irq_high;
      int access_errors;

      function new();
         clear_regs();
         latch_value = '0;
      endfunction

      function void clear_regs();
         cfg_word   = CONFIG_RESET;
         int_status = INTSTS_RESET;
         int_mask   = INTMSK_RESET;
         ctl_word   = CTL_RESET;
         foreach (conv_regs[i]) conv_regs[i] = '0;
         data_fifo.delete();
      endfunction

      function void push_latch(logic [15:0] fresh);
         if (data_fifo.size() < QUEUE_DEPTH) data_fifo.push_back(latch_value);
         else full_drops++;
         latch_value = fresh;
         if (data_fifo.size() > int'(cfg_word[19:16])) begin
            int_status |= INT_QUEUE_BIT;
            queue_irqs++;
         end
      endfunction

      function void run_command(logic [31:0] w);
         logic [3:0]  code;
         logic [6:0]  idx;
         code = w[29:26];
         idx  = w[22:16];
         case (code)
            CMD_READ:  push_latch(conv_regs[idx]);
            CMD_WRITE: conv_regs[idx] = w[15:0];
            CMD_NOP:   push_latch('0);
            default: ;
         endcase
         int_status |= INT_CMD_BIT;
      endfunction

      function void note_access(req_type r);
         rsp_type e;
         int      lvl;
         e = '0;
         if (r.action) begin
            case (r.word_address)
               ADDR_CFG:    cfg_word = r.write_data;
               ADDR_INTSTS: int_status &= ~r.write_data;
               ADDR_INTMSK: int_mask = r.write_data & INTMSK_WMASK;
               ADDR_CFIFO:  run_command(r.write_data);
               ADDR_CTL: begin
                  if (r.write_data[CTL_RESET_POS]) begin
                     clear_regs();
                     soft_resets++;
                  end
                  ctl_word = r.write_data & CTL_WMASK;
               end
               default: e.access_error = 1'b1;
            endcase
         end else begin
            case (r.word_address)
               ADDR_CFG:    e.read_data = cfg_word;
               ADDR_INTSTS: e.read_data = int_status;
               ADDR_INTMSK: e.read_data = int_mask;
               ADDR_CTL:    e.read_data = ctl_word;
               ADDR_STATUS: begin
                  lvl = data_fifo.size();
                  e.read_data = STS_CFIFO_EMPTY | (32'(lvl[3:0]) << 12);
                  if (lvl == 0) e.read_data |= STS_Q_EMPTY;
                  else if (lvl >= QUEUE_DEPTH) e.read_data |= STS_Q_FULL;
               end
               ADDR_DFIFO:
                  if (data_fifo.size() > 0) e.read_data = 32'(data_fifo.pop_front());
               default: e.access_error = 1'b1;
            endcase
         end
         e.irq_level = |(int_status & ~int_mask);
         if (e.irq_level) irq_high++;
         if (e.access_error) access_errors++;
         expected_rsp.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_rsp.size() == 0) begin
            $error("unexpected response beat %h", got);
            errors++;
            return;
         end
         e = expected_rsp.pop_front();
         checked++;
         if (got.read_data !== e.read_data) begin
            $error("read_data expected %h got %h", e.read_data, got.read_data);
            errors++;
         end
         if (got.irq_level !== e.irq_level) begin
            $error("irq_level expected %b got %b", e.irq_level, got.irq_level);
            errors++;
         end
         if (got.access_error !== e.access_error) begin
            $error("access_error expected %b got %b", e.access_error, got.access_error);
            errors++;
         end
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   adc_reg_scoreboard sb = new();
   int beats_sent;
   bit no_gaps;

   adc_command_fifo_register_block DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_payload);
   end

   task automatic bus_access(input logic act, input logic [9:0] addr, input logic [31:0] data);
      req_type r;
      int      gap;
      r.action       = act;
      r.word_address = addr;
      r.write_data   = data;
      gap = no_gaps ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      sb.note_access(r);
      beats_sent++;
   endtask

   function automatic logic [31:0] command_word(logic [3:0] code, logic [6:0] idx,
                                                logic [15:0] data);
      logic [31:0] w;
      w = $urandom;
      w[29:26] = code;
      w[22:16] = idx;
      w[15:0]  = data;
      return w;
   endfunction

   function automatic logic [3:0] rand_code();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return CMD_READ;
         4, 5, 6:    return CMD_WRITE;
         7:          return CMD_NOP;
         default:    return 4'($urandom_range(3, 15));
      endcase
   endfunction

   function automatic logic [6:0] rand_index();
      return ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                         : 7'($urandom_range(0, 7));
   endfunction

   task automatic random_access();
      logic [31:0] d;
      d = $urandom;
      case ($urandom_range(0, 99)) inside
         [0:24]:  bus_access(1'b1, ADDR_CFIFO,
                             command_word(rand_code(), rand_index(), 16'($urandom)));
         [25:44]: bus_access(1'b0, ADDR_DFIFO, d);
         [45:59]: bus_access(1'b0, 10'($urandom_range(0, 6)), d);
         [60:64]: bus_access(1'b1, ADDR_CFG, d);
         [65:69]: bus_access(1'b1, ADDR_INTMSK, ($urandom_range(0, 1)) ? d : (d & 32'h300));
         [70:74]: bus_access(1'b1, ADDR_INTSTS, d);
         [75:79]: begin
            d[CTL_RESET_POS] = ($urandom_range(0, 3) == 0);
            bus_access(1'b1, ADDR_CTL, d);
         end
         [80:89]: case ($urandom_range(0, 3))
            0: bus_access(1'b0, ADDR_CFIFO, d);
            1: bus_access(1'b1, ADDR_STATUS, d);
            2: bus_access(1'b1, ADDR_DFIFO, d);
            default: bus_access(1'($urandom), 10'($urandom_range(7, 1023)), d);
         endcase
         default: bus_access(1'($urandom), 10'($urandom_range(0, 1023)), d);
      endcase
   endtask

   initial begin
      int n;
      reset       <= 1'b1;
      start       <= 1'b0;
      req_payload <= '0;
      no_gaps = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset values and refused accesses
      bus_access(1'b0, ADDR_CFG, 32'hffff_ffff);
      bus_access(1'b0, ADDR_INTSTS, '0);
      bus_access(1'b0, ADDR_INTMSK, '0);
      bus_access(1'b0, ADDR_STATUS, '0);
      bus_access(1'b0, ADDR_CTL, '0);
      bus_access(1'b0, ADDR_DFIFO, '0);
      bus_access(1'b0, ADDR_CFIFO, 32'hffff_ffff);
      bus_access(1'b0, 10'h3ff, '0);
      bus_access(1'b1, ADDR_STATUS, 32'hffff_ffff);
      bus_access(1'b1, ADDR_DFIFO, 32'hffff_ffff);
      bus_access(1'b1, 10'd7, 32'hffff_ffff);
      // commands, unknown code included
      bus_access(1'b1, ADDR_CFIFO, command_word(CMD_WRITE, 7'h7f, 16'hffff));
      bus_access(1'b1, ADDR_CFIFO, command_word(CMD_READ, 7'h7f, 16'h0000));
      bus_access(1'b1, ADDR_CFIFO, command_word(CMD_NOP, 7'h00, 16'h1234));
      bus_access(1'b1, ADDR_CFIFO, 32'hffff_ffff);
      bus_access(1'b1, ADDR_INTMSK, '0);
      bus_access(1'b0, ADDR_STATUS, '0);
      bus_access(1'b0, ADDR_DFIFO, '0);
      bus_access(1'b1, ADDR_INTSTS, 32'hffff_ffff);
      // zero threshold: one push raises the queue interrupt
      bus_access(1'b1, ADDR_CFG, '0);
      bus_access(1'b1, ADDR_CFIFO, command_word(CMD_NOP, 7'h00, 16'h0000));
      bus_access(1'b0, ADDR_INTSTS, '0);
      bus_access(1'b1, ADDR_CTL, 32'hffff_ffff);
      bus_access(1'b1, ADDR_CTL, 32'hffff_ffef);
      bus_access(1'b0, ADDR_CTL, '0);

      while (beats_sent < ITEMS) begin
         no_gaps = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 9))
            0, 1: begin
               n = $urandom_range(12, 20);
               repeat (n)
                  bus_access(1'b1, ADDR_CFIFO,
                             command_word(($urandom_range(0, 3) == 0) ? CMD_NOP : CMD_READ,
                                          rand_index(), 16'($urandom)));
            end
            2: begin
               n = $urandom_range(12, 20);
               repeat (n) begin
                  if ($urandom_range(0, 4) == 0) bus_access(1'b0, ADDR_STATUS, $urandom);
                  else bus_access(1'b0, ADDR_DFIFO, $urandom);
               end
            end
            default: repeat (10) random_access();
         endcase
      end
      start <= 1'b0;

      while (sb.pending() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("tb: %0d beats sent, %0d responses checked, %0d refused accesses",
               beats_sent, sb.checked, sb.access_errors);
      $display("tb: %0d full-queue drops, %0d queue interrupts, %0d soft resets, %0d irq high",
               sb.full_drops, sb.queue_irqs, sb.soft_resets, sb.irq_high);
      if (sb.errors == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end

endmodule
